// File: hdl/scan_polar_to_cartesian_defines.svh
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian assertion macros
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCAN_POLAR_TO_CARTESIAN_DEFINES_SVH
`define SCAN_POLAR_TO_CARTESIAN_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Types, register indexes and constants of the polar to cartesian converter.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned XY_W       = 33;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned PROD_W     = 50;
  localparam int unsigned SUM_W      = 66;
  localparam int unsigned PT_W       = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_OFFSET_X    = 3'd2,
    REG_OFFSET_Y    = 3'd3,
    REG_MIRROR      = 3'd4
  } cfg_reg_t;

  // rotator gain 2608131496 / 2^32, split in two 16-bit halves
  localparam logic [15:0] GAIN_HI = 16'h9B74;
  localparam logic [15:0] GAIN_LO = 16'hEDA8;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic [15:0]            intensity;
    logic                   last;
  } cordic_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] px_hi;
    logic signed [PROD_W-1:0] px_lo;
    logic signed [PROD_W-1:0] py_hi;
    logic signed [PROD_W-1:0] py_lo;
    logic [15:0]              intensity;
    logic                     last;
  } mul_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051D;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2E;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517C;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A2F;
      19:      v = 32'h00000517;
      20:      v = 32'h0000028B;
      21:      v = 32'h00000145;
      22:      v = 32'h000000A2;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/spc_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_cordic_stage
// One rotation-mode CORDIC iteration with a fixed shift and arctangent.
// ----------------------------------------------------------------------------
module spc_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  spc_pkg::cordic_t d_in,
  output spc_pkg::cordic_t d_out
);
  import spc_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = signed'(atan_turn(STAGE));

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = d_in.y >>> STAGE;
  assign dy = d_in.x >>> STAGE;

  always_comb begin
    d_out = d_in;
    if (!d_in.z[Z_W-1]) begin
      d_out.x = d_in.x - dx;
      d_out.y = d_in.y + dy;
      d_out.z = d_in.z - ATAN;
    end else begin
      d_out.x = d_in.x + dx;
      d_out.y = d_in.y - dy;
      d_out.z = d_in.z + ATAN;
    end
  end

endmodule

// File: hdl/spc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_mul
// Quadrant turn of the rotated vector and partial products of the gain.
// ----------------------------------------------------------------------------
module spc_mul (
  input  spc_pkg::cordic_t d_in,
  output spc_pkg::mul_t    d_out
);
  import spc_pkg::*;

  logic signed [XY_W-1:0] fx;
  logic signed [XY_W-1:0] fy;
  logic signed [16:0]     k_hi;
  logic signed [16:0]     k_lo;

  assign k_hi = signed'({1'b0, GAIN_HI});
  assign k_lo = signed'({1'b0, GAIN_LO});

  always_comb begin
    case (d_in.quad)
      2'd1: begin
        fx = -d_in.y;
        fy = d_in.x;
      end
      2'd2: begin
        fx = -d_in.x;
        fy = -d_in.y;
      end
      2'd3: begin
        fx = d_in.y;
        fy = -d_in.x;
      end
      default: begin
        fx = d_in.x;
        fy = d_in.y;
      end
    endcase
  end

  always_comb begin
    d_out.px_hi     = fx * k_hi;
    d_out.px_lo     = fx * k_lo;
    d_out.py_hi     = fy * k_hi;
    d_out.py_lo     = fy * k_lo;
    d_out.intensity = d_in.intensity;
    d_out.last      = d_in.last;
  end

endmodule

// File: hdl/spc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_round
// Gain sum, rounding to millimetres, mounting offset and 18-bit saturation.
// ----------------------------------------------------------------------------
module spc_round (
  input  spc_pkg::mul_t                       d_in,
  input  logic signed [15:0]                  offset_x,
  input  logic signed [15:0]                  offset_y,
  output logic signed [spc_pkg::PT_W-1:0]     point_x,
  output logic signed [spc_pkg::PT_W-1:0]     point_y
);
  import spc_pkg::*;

  localparam logic signed [SUM_W-1:0] RND    = 66'sh200000000000;
  localparam logic signed [20:0]      SAT_HI = 21'sd131071;
  localparam logic signed [20:0]      SAT_LO = -21'sd131072;

  function automatic logic signed [PT_W-1:0] finish(
    input logic signed [PROD_W-1:0] p_hi,
    input logic signed [PROD_W-1:0] p_lo,
    input logic signed [15:0]       off
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [19:0]      mm;
    logic signed [20:0]      s;
    logic signed [PT_W-1:0]  r;
    sum = signed'({p_hi, 16'b0}) + signed'({{16{p_lo[PROD_W-1]}}, p_lo}) + RND;
    mm  = sum[SUM_W-1:46];
    s   = signed'({mm[19], mm}) + signed'({{5{off[15]}}, off});
    if (s > SAT_HI) begin
      r = SAT_HI[PT_W-1:0];
    end else if (s < SAT_LO) begin
      r = SAT_LO[PT_W-1:0];
    end else begin
      r = s[PT_W-1:0];
    end
    return r;
  endfunction

  assign point_x = finish(d_in.px_hi, d_in.px_lo, offset_x);
  assign point_y = finish(d_in.py_hi, d_in.py_lo, offset_y);

endmodule

// File: hdl/scan_polar_to_cartesian.sv
`timescale 1ns / 1ps
// An accepted word passes cord_r[0], the stage registers, mul_r and the output registers.
// One word per cycle unless stalled; fully pipelined CORDIC, one stage per iteration.
// A stalled output freezes the pipeline; one more input word is held in a skid register.
// Reset (synchronous, rst_n low) clears the config registers, the angle accumulator, the
// skid flag and the valid flags; pipeline data registers keep their contents.
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian
// Lidar range samples to cartesian points through a pipelined CORDIC rotator.
// ----------------------------------------------------------------------------
`include "scan_polar_to_cartesian_defines.svh"

module scan_polar_to_cartesian #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [15:0]                          in_range_mm,
  input  logic [15:0]                          in_intensity,
  input  logic                                 in_scan_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [spc_pkg::PT_W-1:0]      out_point_x,
  output logic signed [spc_pkg::PT_W-1:0]      out_point_y,
  output logic [15:0]                          out_point_intensity,
  output logic                                 out_point_last,
  input  logic                                 cfg_wr_en,
  input  logic [spc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import spc_pkg::*;

  localparam int unsigned NV = CORDIC_STAGES + 3;

  logic [15:0]        start_angle_r;
  logic [15:0]        angle_step_r;
  logic signed [15:0] offset_x_r;
  logic signed [15:0] offset_y_r;
  logic               mirror_r;
  logic [15:0]        acc_r;
  logic [15:0]        acc_nxt;

  logic               in_acc;
  logic               pipe_en;
  logic               skid_full_r;
  logic               skid_full_nxt;
  cordic_t            skid_r;
  cordic_t            in_cord;
  cordic_t            s0_nxt;
  logic [NV-1:0]      vld_r;

  cordic_t            cord_r   [CORDIC_STAGES+1];
  cordic_t            cord_nxt [CORDIC_STAGES+1];
  mul_t               mul_nxt;
  mul_t               mul_r;
  logic signed [PT_W-1:0] pt_x_nxt;
  logic signed [PT_W-1:0] pt_y_nxt;

  logic [15:0]        ang;
  logic [15:0]        ang_bias;
  logic [1:0]         quad;
  logic [15:0]        resid;
  logic signed [16:0] rng;

  assign in_stall = skid_full_r;
  assign in_acc   = in_valid && !skid_full_r;
  assign pipe_en  = !vld_r[NV-1] || !out_stall;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      mirror_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_ANGLE: start_angle_r <= cfg_wdata;
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata;
        REG_OFFSET_X:    offset_x_r    <= signed'(cfg_wdata);
        REG_OFFSET_Y:    offset_y_r    <= signed'(cfg_wdata);
        REG_MIRROR:      mirror_r      <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // angle reduction to a quadrant and a residual of at most an eighth turn
  always_comb begin
    ang      = start_angle_r + acc_r;
    ang_bias = ang + 16'h2000;
    quad     = ang_bias[15:14];
    resid    = ang - {quad, 14'b0};
    rng      = mirror_r ? -signed'({1'b0, in_range_mm}) : signed'({1'b0, in_range_mm});
    in_cord.x         = signed'({{2{rng[16]}}, rng, 14'b0});
    in_cord.y         = '0;
    in_cord.z         = signed'({resid, 16'b0});
    in_cord.quad      = quad;
    in_cord.intensity = in_intensity;
    in_cord.last      = in_scan_end;
  end

  assign acc_nxt = in_scan_end ? 16'd0 : acc_r + angle_step_r;
  assign s0_nxt  = skid_full_r ? skid_r : in_cord;

  always_comb begin
    if (skid_full_r) begin
      skid_full_nxt = !pipe_en;
    end else begin
      skid_full_nxt = in_acc && !pipe_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      skid_full_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (in_acc) begin
        acc_r <= acc_nxt;
      end
      skid_full_r <= skid_full_nxt;
      if (pipe_en) begin
        vld_r <= {vld_r[NV-2:0], skid_full_r || in_acc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !pipe_en) begin
      skid_r <= in_cord;
    end
  end

  assign cord_nxt[0] = s0_nxt;

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
    spc_cordic_stage #(
      .STAGE(k - 1)
    ) u_stage (
      .d_in  (cord_r[k-1]),
      .d_out (cord_nxt[k])
    );
  end

  for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        cord_r[k] <= cord_nxt[k];
      end
    end
  end

  spc_mul u_mul (
    .d_in  (cord_r[CORDIC_STAGES]),
    .d_out (mul_nxt)
  );

  spc_round u_round (
    .d_in     (mul_r),
    .offset_x (offset_x_r),
    .offset_y (offset_y_r),
    .point_x  (pt_x_nxt),
    .point_y  (pt_y_nxt)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mul_r               <= mul_nxt;
      out_point_x         <= pt_x_nxt;
      out_point_y         <= pt_y_nxt;
      out_point_intensity <= mul_r.intensity;
      out_point_last      <= mul_r.last;
    end
  end

  `SPC_ASSERT_NXT(a_scan_end_rewinds, in_acc && in_scan_end, acc_r == 16'd0,
    "angle accumulator not rewound after last sample")
  `SPC_ASSERT_NXT(a_step_advances, in_acc && !in_scan_end,
    acc_r == $past(acc_r) + $past(angle_step_r), "angle accumulator missed its step")
  `SPC_ASSERT_NXT(a_frozen_pipe, !pipe_en, $stable(vld_r), "pipeline moved while output stalled")
  `SPC_ASSERT_IMP(a_skid_only_when_blocked, skid_full_r, out_valid,
    "skid word held without a waiting output word")

endmodule

// File: verif/scan_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_point_checker
// Watches the sample, point and register ports of the polar to cartesian
// converter. Tracks the register file and the scan angle, predicts each point
// with a bit-exact CORDIC rotation, and compares accepted points in order.
// ----------------------------------------------------------------------------
module scan_point_checker #(
  parameter int unsigned STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [15:0]                          in_range_mm,
  input  logic [15:0]                          in_intensity,
  input  logic                                 in_scan_end,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [spc_pkg::PT_W-1:0]      out_point_x,
  input  logic signed [spc_pkg::PT_W-1:0]      out_point_y,
  input  logic [15:0]                          out_point_intensity,
  input  logic                                 out_point_last,
  input  logic                                 cfg_wr_en,
  input  logic [spc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output int                                   faults,
  output int                                   points_pending
);
  import spc_pkg::*;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic [15:0]            intensity;
    logic                   last;
  } point_t;

  localparam longint GAIN_NUM   = 64'sd2608131496;
  localparam longint ROUND_HALF = 64'sh0000_2000_0000_0000;
  localparam longint PT_MAX     = 64'sd131071;
  localparam longint PT_MIN     = -64'sd131072;

  logic [15:0]        start_angle;
  logic [15:0]        angle_step;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic               mirror;
  logic [15:0]        sweep_angle;
  point_t             expected_points[$];
  point_t             want;

  function automatic longint arctan_turn(input int unsigned i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051D;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2E;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2F9;
      15:      return 64'h0000517C;
      16:      return 64'h000028BE;
      17:      return 64'h0000145F;
      18:      return 64'h00000A2F;
      19:      return 64'h00000517;
      20:      return 64'h0000028B;
      21:      return 64'h00000145;
      22:      return 64'h000000A2;
      default: return 64'h00000051;
    endcase
  endfunction

  // apply gain, round half up to mm, add offset, saturate
  function automatic logic signed [PT_W-1:0] scale_to_mm(input longint v,
                                                         input logic signed [15:0] off);
    longint s;
    s = ((v * GAIN_NUM + ROUND_HALF) >>> 46) + longint'(off);
    if (s > PT_MAX) s = PT_MAX;
    else if (s < PT_MIN) s = PT_MIN;
    return s[PT_W-1:0];
  endfunction

  function automatic point_t rotate_sample(input logic [15:0] rng,
                                           input logic [15:0] inten,
                                           input logic last);
    logic [15:0] ang;
    logic [15:0] shifted;
    logic [1:0]  quad;
    logic [15:0] resid;
    longint      px, py, pz, dx, dy, fx, fy;
    point_t      p;
    ang = start_angle + sweep_angle;
    shifted = ang + 16'h2000;
    quad = shifted[15:14];
    resid = ang - {quad, 14'd0};
    px = mirror ? -longint'(rng) : longint'(rng);
    px = px * 16384;
    py = 0;
    pz = longint'($signed(resid)) * 65536;
    for (int unsigned i = 0; i < STAGES && i < 24; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (pz >= 0) begin
        px = px - dx;
        py = py + dy;
        pz = pz - arctan_turn(i);
      end else begin
        px = px + dx;
        py = py - dy;
        pz = pz + arctan_turn(i);
      end
    end
    case (quad)
      2'd1: begin
        fx = -py;
        fy = px;
      end
      2'd2: begin
        fx = -px;
        fy = -py;
      end
      2'd3: begin
        fx = py;
        fy = -px;
      end
      default: begin
        fx = px;
        fy = py;
      end
    endcase
    p.x = scale_to_mm(fx, offset_x);
    p.y = scale_to_mm(fy, offset_y);
    p.intensity = inten;
    p.last = last;
    return p;
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] %s", $realtime, msg);
    faults++;
  endtask

  initial faults = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start_angle = '0;
      angle_step = '0;
      offset_x = '0;
      offset_y = '0;
      mirror = 1'b0;
      sweep_angle = '0;
      expected_points.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_ANGLE: start_angle = cfg_wdata;
          REG_ANGLE_STEP:  angle_step = cfg_wdata;
          REG_OFFSET_X:    offset_x = cfg_wdata;
          REG_OFFSET_Y:    offset_y = cfg_wdata;
          REG_MIRROR:      mirror = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_points = {expected_points,
                           rotate_sample(in_range_mm, in_intensity, in_scan_end)};
        if (in_scan_end) sweep_angle = '0;
        else sweep_angle = sweep_angle + angle_step;
      end
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_fault($sformatf("unexpected point x=%0d y=%0d", out_point_x, out_point_y));
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x)
            report_fault($sformatf("point_x got %0d want %0d", out_point_x, want.x));
          if (out_point_y !== want.y)
            report_fault($sformatf("point_y got %0d want %0d", out_point_y, want.y));
          if (out_point_intensity !== want.intensity)
            report_fault($sformatf("point_intensity got %h want %h",
                                   out_point_intensity, want.intensity));
          if (out_point_last !== want.last)
            report_fault($sformatf("point_last got %b want %b", out_point_last, want.last));
        end
      end
    end
    points_pending <= expected_points.size();
  end

endmodule

// File: verif/scan_polar_to_cartesian_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_polar_to_cartesian_test
// Drives range samples through the converter: a directed pass over angle
// boundaries, field extremes and mirror mode, then randomized scans under
// several register settings, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module scan_polar_to_cartesian_test;
  import spc_pkg::*;

  localparam int unsigned STAGES         = 16;
  localparam int          LATENCY        = STAGES + 3;
  localparam int          PHASES         = 10;
  localparam int          PHASE_WORDS    = 58;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [15:0]            in_range_mm = '0;
  logic [15:0]            in_intensity = '0;
  logic                   in_scan_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [PT_W-1:0] out_point_x;
  logic signed [PT_W-1:0] out_point_y;
  logic [15:0]            out_point_intensity;
  logic                   out_point_last;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int          faults;
  int          points_pending;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          stall_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  scan_polar_to_cartesian #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_range_mm        (in_range_mm),
    .in_intensity       (in_intensity),
    .in_scan_end        (in_scan_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_intensity(out_point_intensity),
    .out_point_last     (out_point_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  scan_point_checker #(
    .STAGES(STAGES)
  ) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_range_mm        (in_range_mm),
    .in_intensity       (in_intensity),
    .in_scan_end        (in_scan_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_point_x        (out_point_x),
    .out_point_y        (out_point_y),
    .out_point_intensity(out_point_intensity),
    .out_point_last     (out_point_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .faults             (faults),
    .points_pending     (points_pending)
  );

  // output stall: switch among four patterns, picked at random
  always @(posedge clk) begin
    if (stall_cycles == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_cycles <= $urandom_range(8, 60);
    end else begin
      stall_cycles <= stall_cycles - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_cycles[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [15:0] rng, input logic [15:0] inten,
                           input logic last);
    in_valid <= 1'b1;
    in_range_mm <= rng;
    in_intensity <= inten;
    in_scan_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [15:0] start, input logic [15:0] step,
                            input logic [15:0] off_x, input logic [15:0] off_y,
                            input logic [15:0] mirror_word);
    drain();
    repeat (LATENCY) @(posedge clk);
    write_reg(REG_START_ANGLE, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_OFFSET_X, off_x);
    write_reg(REG_OFFSET_Y, off_y);
    write_reg(REG_MIRROR, mirror_word);
    for (int k = int'(REG_MIRROR) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 16'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      3:       return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int scan_len;
    int sent;
    logic last;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero step, every sample at angle zero
    send_word(16'h0000, 16'h0000, 1'b0);
    send_word(16'hFFFF, 16'hFFFF, 1'b0);
    send_word(16'h0001, 16'h5555, 1'b1);
    send_word(16'h8000, 16'hAAAA, 1'b0);

    // just below each octant boundary, wrapping through a full turn
    load_setup(16'h1FFF, 16'h2000, 16'h7FFF, 16'h8000, 16'h0000);
    for (int i = 0; i < 8; i++)
      send_word(16'hFFFF, 16'(i * 16'h2222), i == 7);

    // exactly on the boundaries, mirrored
    load_setup(16'h2000, 16'h2000, 16'h8000, 16'h7FFF, 16'hFFFF);
    for (int i = 0; i < 8; i++)
      send_word(16'hFFFF - 16'(i), 16'hFFFF - 16'(i * 16'h1111), i == 7);

    for (int phase = 0; phase < PHASES; phase++) begin
      load_setup(pick_angle(), pick_step(), pick_offset(), pick_offset(), 16'($urandom));
      sent = 0;
      while (sent < PHASE_WORDS) begin
        scan_len = $urandom_range(1, 40);
        if (scan_len > PHASE_WORDS - sent) scan_len = PHASE_WORDS - sent;
        for (int k = 0; k < scan_len; k++) begin
          pace();
          if ((phase == 2 && sent == PHASE_WORDS / 2) || $urandom_range(0, 199) == 0)
            drain();
          last = (k == scan_len - 1) || ($urandom_range(0, 49) == 0);
          send_word(pick_range(), 16'($urandom), last);
          sent++;
        end
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (faults == 0 && points_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
